// ===== src/ecdf_pkg.sv =====
// Package for the ECDF dominance counter: request codes, register indexes,
// default parameter values and the control word that travels down the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package ecdf_pkg;

    // Default parameter values
    localparam int NPOINTS_DEF    = 64;
    localparam int DIM_DEF        = 4;
    localparam int COMP_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int IN_COMPS  = 4;
    localparam int IN_W      = 16;
    localparam int CNT_W     = 32;
    localparam int SLOT_W    = 6;
    localparam int REQ_W     = 2;
    localparam int DIMS_W    = 3;
    localparam int PTS_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'd1;

    // Register reset values
    localparam logic [DIMS_W-1:0] DIMS_RST   = 3'd1;
    localparam logic [PTS_W-1:0]  POINTS_RST = 7'd64;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_READ   = 2'd2
    } req_e_t;

    // Spare request code, ignored by the block
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Control word handed from cell to cell
    typedef struct packed {
        logic                valid;
        req_e_t              req;
        logic [SLOT_W-1:0]   slot;
        logic [DIMS_W-1:0]   nd;    // active components, already clamped
        logic [PTS_W-1:0]    np;    // points in use, zero taken as one
    } ctl_t;

endpackage

// ===== src/ecdf_dominance_counter_top.sv =====
// ECDF dominance counter, top level: input decode, configuration registers,
// sample total, a chain of NPOINTS cells and the result register.
// Depends on ecdf_pkg and ecdf_cell.
// A read result passes through every cell register and then the result register.
// Throughput: one transaction per cycle unless the chain stalls; every transaction walks
// the cell chain in order. The chain stalls only when a read reaches its end while the
// previous result waits. Reset: counts, sample total and control clear at once; query
// points are undefined until loaded; dims_reg resets to 1 and points_reg to 64.
`timescale 1ns / 1ps

module ecdf_dominance_counter_top #(
    parameter int NPOINTS    = ecdf_pkg::NPOINTS_DEF,
    parameter int DIM        = ecdf_pkg::DIM_DEF,
    parameter int COMP_WIDTH = ecdf_pkg::COMP_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ecdf_pkg::REQ_W-1:0]        req_type,
    input  logic [ecdf_pkg::SLOT_W-1:0]       point_index,
    input  logic signed [ecdf_pkg::IN_W-1:0]  comp0,
    input  logic signed [ecdf_pkg::IN_W-1:0]  comp1,
    input  logic signed [ecdf_pkg::IN_W-1:0]  comp2,
    input  logic signed [ecdf_pkg::IN_W-1:0]  comp3,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ecdf_pkg::SLOT_W-1:0]       read_index,
    output logic [ecdf_pkg::CNT_W-1:0]        hit_count,
    output logic [ecdf_pkg::CNT_W-1:0]        samples_seen,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ecdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ecdf_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int MaxDims = (DIM < ecdf_pkg::IN_COMPS) ? DIM : ecdf_pkg::IN_COMPS;
    localparam int PW      = MaxDims * COMP_WIDTH;

    logic [ecdf_pkg::IN_W-1:0]    comp_in [ecdf_pkg::IN_COMPS];
    logic [PW-1:0]                comps_ext;

    logic [ecdf_pkg::DIMS_W-1:0]  dims_reg;
    logic [ecdf_pkg::PTS_W-1:0]   points_reg;
    logic [ecdf_pkg::DIMS_W-1:0]  dims_eff;
    logic [ecdf_pkg::PTS_W-1:0]   points_eff;
    logic [ecdf_pkg::CNT_W-1:0]   total_reg;
    logic [ecdf_pkg::CNT_W-1:0]   total_next;

    logic                         advance;
    logic                         in_fire;
    ecdf_pkg::ctl_t               head_ctl;

    // chain links: link k feeds cell k, link NPOINTS is the chain end
    ecdf_pkg::ctl_t               link_ctl   [NPOINTS+1];
    logic [PW-1:0]                link_comps [NPOINTS+1];
    logic [ecdf_pkg::CNT_W-1:0]   link_count [NPOINTS+1];
    logic [ecdf_pkg::CNT_W-1:0]   link_total [NPOINTS+1];

    logic                         tail_read;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ecdf_pkg::SLOT_W-1:0]  read_index_reg;
    logic [ecdf_pkg::CNT_W-1:0]   hit_count_reg;
    logic [ecdf_pkg::CNT_W-1:0]   samples_seen_reg;

    assign comp_in[0] = comp0;
    assign comp_in[1] = comp1;
    assign comp_in[2] = comp2;
    assign comp_in[3] = comp3;

    // Low COMP_WIDTH bits per component, sign at bit COMP_WIDTH-1; zero-extended if wider
    genvar gd;
    generate
        for (gd = 0; gd < MaxDims; gd++)
        begin : g_ext
            if (COMP_WIDTH <= ecdf_pkg::IN_W)
            begin : g_narrow
                assign comps_ext[gd*COMP_WIDTH +: COMP_WIDTH] =
                    comp_in[gd][COMP_WIDTH-1:0];
            end
            else
            begin : g_wide
                assign comps_ext[gd*COMP_WIDTH +: COMP_WIDTH] =
                    {{(COMP_WIDTH-ecdf_pkg::IN_W){1'b0}}, comp_in[gd]};
            end
        end
    endgenerate

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg   <= ecdf_pkg::DIMS_RST;
            points_reg <= ecdf_pkg::POINTS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ecdf_pkg::CFG_DIMS:   dims_reg   <= cfg_data[ecdf_pkg::DIMS_W-1:0];
                ecdf_pkg::CFG_POINTS: points_reg <= cfg_data;
                default:              dims_reg   <= dims_reg;
            endcase
        end
    end

    // Clamp settings once, at chain entry
    always_comb
    begin
        if (dims_reg == '0)
            dims_eff = ecdf_pkg::DIMS_W'(1);
        else if (int'(dims_reg) > MaxDims)
            dims_eff = ecdf_pkg::DIMS_W'(MaxDims);
        else
            dims_eff = dims_reg;
        points_eff = (points_reg == '0) ? ecdf_pkg::PTS_W'(1) : points_reg;
    end

    // Chain moves unless a read at its end finds the result register held
    assign tail_read = link_ctl[NPOINTS].valid &&
                       (link_ctl[NPOINTS].req == ecdf_pkg::REQ_READ);
    assign advance   = !(tail_read && out_valid_reg && !out_ready);
    assign in_ready  = advance;
    assign in_fire   = in_valid && in_ready;

    // Head of the chain; the spare request code enters as a bubble
    always_comb
    begin
        head_ctl       = '0;
        head_ctl.valid = in_fire && (req_type != ecdf_pkg::REQ_UNUSED);
        head_ctl.req   = ecdf_pkg::req_e_t'(req_type);
        head_ctl.slot  = point_index;
        head_ctl.nd    = dims_eff;
        head_ctl.np    = points_eff;
    end

    assign link_ctl[0]   = head_ctl;
    assign link_comps[0] = comps_ext;
    assign link_count[0] = '0;
    assign link_total[0] = total_reg;

    // Sample total, counted as samples enter
    always_comb
    begin
        total_next = total_reg;
        if (head_ctl.valid && (head_ctl.req == ecdf_pkg::REQ_SAMPLE) && (total_reg != '1))
            total_next = total_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else
            total_reg <= total_next;
    end

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < NPOINTS; gi++)
        begin : g_cell
            ecdf_cell #(
                .IDX        (gi),
                .NDIM       (MaxDims),
                .COMP_WIDTH (COMP_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .ctl_in    (link_ctl[gi]),
                .comps_in  (link_comps[gi]),
                .count_in  (link_count[gi]),
                .total_in  (link_total[gi]),
                .ctl_out   (link_ctl[gi+1]),
                .comps_out (link_comps[gi+1]),
                .count_out (link_count[gi+1]),
                .total_out (link_total[gi+1])
            );
        end
    endgenerate

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && tail_read)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_read)
        begin
            read_index_reg   <= link_ctl[NPOINTS].slot;
            hit_count_reg    <= link_count[NPOINTS];
            samples_seen_reg <= link_total[NPOINTS];
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_index   = read_index_reg;
    assign hit_count    = hit_count_reg;
    assign samples_seen = samples_seen_reg;

endmodule

// ===== src/ecdf_cell.sv =====
// One cell of the ECDF chain: holds one query point and its hit count,
// and acts on each transaction as it passes through.
// Depends on ecdf_pkg.
`timescale 1ns / 1ps

module ecdf_cell #(
    parameter int IDX        = 0,
    parameter int NDIM       = 4,
    parameter int COMP_WIDTH = ecdf_pkg::COMP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  ecdf_pkg::ctl_t                ctl_in,
    input  logic [NDIM*COMP_WIDTH-1:0]    comps_in,
    input  logic [ecdf_pkg::CNT_W-1:0]    count_in,
    input  logic [ecdf_pkg::CNT_W-1:0]    total_in,
    output ecdf_pkg::ctl_t                ctl_out,
    output logic [NDIM*COMP_WIDTH-1:0]    comps_out,
    output logic [ecdf_pkg::CNT_W-1:0]    count_out,
    output logic [ecdf_pkg::CNT_W-1:0]    total_out
);

    logic signed [COMP_WIDTH-1:0]   point_reg [NDIM];
    logic [ecdf_pkg::CNT_W-1:0]     hits_reg;
    logic [ecdf_pkg::CNT_W-1:0]     hits_next;
    ecdf_pkg::ctl_t                 ctl_reg;
    logic [NDIM*COMP_WIDTH-1:0]     comps_reg;
    logic [ecdf_pkg::CNT_W-1:0]     count_reg;
    logic [ecdf_pkg::CNT_W-1:0]     count_next;
    logic [ecdf_pkg::CNT_W-1:0]     total_reg;
    logic                           dominated;
    logic                           slot_hit;
    logic                           in_use;
    logic                           load_en;

    assign slot_hit = (int'(ctl_in.slot) == IDX);
    assign in_use   = (IDX < int'(ctl_in.np));

    // Sample is dominated when every active component is <= the point's
    always_comb
    begin
        dominated = 1'b1;
        for (int d = 0; d < NDIM; d++)
        begin
            if ((d < int'(ctl_in.nd)) &&
                ($signed(comps_in[d*COMP_WIDTH +: COMP_WIDTH]) > point_reg[d]))
            begin
                dominated = 1'b0;
            end
        end
    end

    // Per-request action of this cell
    always_comb
    begin
        hits_next  = hits_reg;
        count_next = count_in;
        load_en    = 1'b0;
        if (ctl_in.valid)
        begin
            case (ctl_in.req)
                ecdf_pkg::REQ_LOAD:
                begin
                    load_en = slot_hit;
                end
                ecdf_pkg::REQ_SAMPLE:
                begin
                    if (in_use && dominated && (hits_reg != '1))
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                ecdf_pkg::REQ_READ:
                begin
                    if (slot_hit)
                    begin
                        count_next = hits_reg;
                    end
                end
                default:
                begin
                    count_next = count_in;
                end
            endcase
        end
    end

    // Hit counter and control register, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
            ctl_reg  <= '0;
        end
        else if (advance)
        begin
            hits_reg <= hits_next;
            ctl_reg  <= ctl_in;
        end
    end

    // Point storage and travelling payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            comps_reg <= comps_in;
            count_reg <= count_next;
            total_reg <= total_in;
            if (load_en)
            begin
                for (int d = 0; d < NDIM; d++)
                begin
                    point_reg[d] <= $signed(comps_in[d*COMP_WIDTH +: COMP_WIDTH]);
                end
            end
        end
    end

    assign ctl_out   = ctl_reg;
    assign comps_out = comps_reg;
    assign count_out = count_reg;
    assign total_out = total_reg;

endmodule

// ===== src/ecdf_checker.sv =====
// Port-level checks for the ECDF dominance counter, bound to the top level.
// Depends on ecdf_pkg.
`timescale 1ns / 1ps

module ecdf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ecdf_pkg::SLOT_W-1:0]       read_index,
    input logic [ecdf_pkg::CNT_W-1:0]        hit_count,
    input logic [ecdf_pkg::CNT_W-1:0]        samples_seen
);

    logic [ecdf_pkg::CNT_W-1:0] last_seen_reg;

    // samples_seen of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_seen_reg <= '0;
        else if (out_valid && out_ready)
            last_seen_reg <= samples_seen;
    end

    // no result shows while reset is held
    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a point never counts more samples than were seen
    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_count <= samples_seen))
        else $error("hit_count exceeds samples_seen");

    // the sample total never goes backward between results
    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> (samples_seen >= last_seen_reg))
        else $error("samples_seen decreased");

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(read_index) && $stable(hit_count) && $stable(samples_seen)))
        else $error("stalled result changed");

endmodule

bind ecdf_dominance_counter_top ecdf_checker u_ecdf_checker (.*);
